[hdl/utf8s_pkg.sv]
// utf8s_pkg: shared types and byte constants for the UTF-8 sanitizer.
// No dependencies; the unit, the decode step and the result queue import this package.
`timescale 1ns / 1ps

package utf8s_pkg;

  // Most result items one input item can cause
  localparam int MAX_RES = 4;

  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam logic [7:0] ASCII_MAX  = 8'h7F;
  localparam logic [7:0] CONT_LO    = 8'h80;
  localparam logic [7:0] CONT_HI    = 8'hBF;
  localparam logic [7:0] LEAD2_LO   = 8'hC2;
  localparam logic [7:0] LEAD2_HI   = 8'hDF;
  localparam logic [7:0] LEAD3_LO   = 8'hE0;
  localparam logic [7:0] LEAD3_HI   = 8'hEF;
  localparam logic [7:0] LEAD4_LO   = 8'hF0;
  localparam logic [7:0] LEAD4_HI   = 8'hF4;

  // Second-byte limits for the special lead bytes
  localparam logic [7:0] LEAD_E0    = 8'hE0;
  localparam logic [7:0] LEAD_ED    = 8'hED;
  localparam logic [7:0] LEAD_F0    = 8'hF0;
  localparam logic [7:0] LEAD_F4    = 8'hF4;
  localparam logic [7:0] E0_SEC_MIN = 8'hA0;
  localparam logic [7:0] ED_SEC_MAX = 8'h9F;
  localparam logic [7:0] F0_SEC_MIN = 8'h90;
  localparam logic [7:0] F4_SEC_MAX = 8'h8F;

  typedef logic [1:0] held_cnt_t;
  typedef logic [2:0] seq_len_t;
  typedef logic [2:0] res_cnt_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_last;
  } res_t;

  // All result items of one input item, in order; cnt of them are valid
  typedef struct packed {
    res_cnt_t              cnt;
    res_t [MAX_RES-1:0]    res;
  } res_grp_t;

endpackage

[hdl/utf8s_if.sv]
// utf8s_if: valid/ready channel interfaces for the sanitizer's input and result items.
// No dependencies.
`timescale 1ns / 1ps

interface utf8s_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface utf8s_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       text_last;

  modport source (output valid, output out_byte, output run_last, output text_last,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input text_last,
                  output ready);
endinterface

[hdl/utf8_sanitizer_unit.sv]
// An item is taken into the input register and decoded from there once the queue has room
// for a full group; its results are then written into the result queue. Throughput: one
// item per cycle while the result queue holds no more than FIFO_DEPTH - 4 items; results
// leave at one per cycle while out_if.ready is high, and over a text one result leaves
// per item. Reset (synchronous, active low) empties the input register and the queue and
// returns the decoder to idle with nothing held.
`timescale 1ns / 1ps

module utf8_sanitizer_unit import utf8s_pkg::*; #(
  // Result queue depth: a power of two, at least 4
  parameter int FIFO_DEPTH = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  utf8s_in_if.sink     in_if,
  utf8s_out_if.source  out_if
);

  // Input register: holds one item until the decoder can place all of its
  // results in the queue.
  logic     in_v_r;
  in_item_t in_item_r;
  logic     accept;

  // Decoder / queue handshake
  logic     fire;
  logic     room;
  res_grp_t grp;
  logic     head_valid;
  res_t     head;
  logic     pop;

  // Advance the held item when the queue has room for a full group; this
  // depends only on registered state, so in_if.ready has no path from out_if.
  assign fire        = in_v_r && room;
  assign in_if.ready = !in_v_r || room;
  assign accept      = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_if.ready) begin
      in_v_r <= in_if.valid;
    end
  end

  // Payload register needs no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      in_item_r.in_byte     <= in_if.in_byte;
      in_item_r.end_of_text <= in_if.end_of_text;
    end
  end

  // Decode the item against the held sequence: emit completed characters,
  // turn failed or unfinished bytes into spaces, or hold a partial sequence.
  utf8s_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (in_item_r),
    .grp   (grp)
  );

  // Queue the group (zero to four items) and drain one item per cycle while out_if.ready is high.
  utf8s_res_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (fire),
    .grp        (grp),
    .room       (room),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  assign out_if.valid     = head_valid;
  assign out_if.out_byte  = head.out_byte;
  assign out_if.run_last  = head.run_last;
  assign out_if.text_last = head.text_last;
  assign pop              = head_valid && out_if.ready;

endmodule

[hdl/utf8s_step.sv]
// utf8s_step: sequence state and the per-item decode that yields a group of results.
// Depends on utf8s_pkg.
`timescale 1ns / 1ps

module utf8s_step import utf8s_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     fire,
  input  in_item_t item,
  output res_grp_t grp
);

  logic [7:0] held_r [3];
  held_cnt_t  cnt_r, cnt_nxt;
  seq_len_t   len_r, len_nxt;

  logic [7:0] b;
  logic       eot;
  seq_len_t   lead_len;
  logic       fresh_emit;
  logic [7:0] fresh_byte;
  logic       in_seq, ok, done;
  res_cnt_t   pre_cnt;
  logic       pre_keep;
  logic       tail_v;
  logic [7:0] tail_byte;
  logic       wr_lead, wr_cont;
  res_cnt_t   n;
  logic [7:0] pre_byte [MAX_RES];

  function automatic logic cont_ok(input logic [7:0] lead, input held_cnt_t pos,
                                   input logic [7:0] cb);
    logic r;
    r = (cb >= CONT_LO) && (cb <= CONT_HI);
    if (pos == held_cnt_t'(1)) begin
      if (lead == LEAD_E0 && cb < E0_SEC_MIN) r = 1'b0;
      if (lead == LEAD_ED && cb > ED_SEC_MAX) r = 1'b0;
      if (lead == LEAD_F0 && cb < F0_SEC_MIN) r = 1'b0;
      if (lead == LEAD_F4 && cb > F4_SEC_MAX) r = 1'b0;
    end
    return r;
  endfunction

  assign b   = item.in_byte;
  assign eot = item.end_of_text;

  // Classify the byte as a fresh start
  always_comb begin
    lead_len   = '0;
    fresh_emit = 1'b1;
    fresh_byte = SPACE_BYTE;
    case (b) inside
      [8'h00:ASCII_MAX]:   fresh_byte = b;
      [LEAD2_LO:LEAD2_HI]: begin lead_len = 3'd2; fresh_emit = 1'b0; end
      [LEAD3_LO:LEAD3_HI]: begin lead_len = 3'd3; fresh_emit = 1'b0; end
      [LEAD4_LO:LEAD4_HI]: begin lead_len = 3'd4; fresh_emit = 1'b0; end
      default: ;
    endcase
  end

  assign in_seq = (cnt_r != '0) && (len_r > {1'b0, cnt_r});
  assign ok     = cont_ok(held_r[0], cnt_r, b);
  assign done   = (({1'b0, cnt_r}) + 3'd1) == len_r;

  // Results are a prefix (held bytes or spaces) and at most one tail byte
  always_comb begin
    pre_cnt   = '0;
    pre_keep  = 1'b0;
    tail_v    = 1'b0;
    tail_byte = fresh_byte;
    cnt_nxt   = '0;
    len_nxt   = '0;
    wr_lead   = 1'b0;
    wr_cont   = 1'b0;
    if (in_seq && ok && done) begin
      pre_cnt   = {1'b0, cnt_r};
      pre_keep  = 1'b1;
      tail_v    = 1'b1;
      tail_byte = b;
    end else if (in_seq && ok) begin
      wr_cont = 1'b1;
      if (eot) begin
        pre_cnt = {1'b0, cnt_r} + 3'd1;
      end else begin
        cnt_nxt = cnt_r + 2'd1;
        len_nxt = len_r;
      end
    end else begin
      pre_cnt = in_seq ? {1'b0, cnt_r} : '0;
      if (fresh_emit || eot) begin
        tail_v = 1'b1;
      end else begin
        wr_lead = 1'b1;
        cnt_nxt = 2'd1;
        len_nxt = lead_len;
      end
    end
  end

  assign n = pre_cnt + res_cnt_t'(tail_v);

  always_comb begin
    for (int k = 0; k < MAX_RES - 1; k++) begin
      pre_byte[k] = pre_keep ? held_r[k] : SPACE_BYTE;
    end
    pre_byte[MAX_RES-1] = SPACE_BYTE;
  end

  always_comb begin
    grp.cnt = fire ? n : '0;
    for (int k = 0; k < MAX_RES; k++) begin
      grp.res[k].out_byte  = (res_cnt_t'(k) < pre_cnt) ? pre_byte[k] : tail_byte;
      grp.res[k].run_last  = (res_cnt_t'(k + 1) == n);
      grp.res[k].text_last = (res_cnt_t'(k + 1) == n) && eot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      len_r <= '0;
    end else if (fire) begin
      cnt_r <= cnt_nxt;
      len_r <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && wr_lead) held_r[0] <= b;
    if (fire && wr_cont) begin
      case (cnt_r)
        2'd1:    held_r[1] <= b;
        2'd2:    held_r[2] <= b;
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_held_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> (len_r > {1'b0, cnt_r}))
    else $error("held count not below sequence length");

  a_eot_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && eot) |-> (grp.cnt != '0))
    else $error("end of text produced no result");

  a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && eot) |=> (cnt_r == '0 && len_r == '0))
    else $error("state not idle after end of text");
`endif

endmodule

[hdl/utf8s_res_fifo.sv]
// utf8s_res_fifo: result queue that takes a group of up to MAX_RES items per cycle
// and hands out one per cycle while pop is high. Depends on utf8s_pkg.
`timescale 1ns / 1ps

module utf8s_res_fifo import utf8s_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  res_grp_t grp,
  output logic     room,
  output logic     head_valid,
  output res_t     head,
  input  logic     pop
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  res_t          mem_r [DEPTH];
  logic [AW-1:0] rd_ptr_r, wr_ptr_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] push_n;

  assign push_n     = push ? CW'(grp.cnt) : '0;
  assign count_nxt  = count_r + push_n - CW'(pop);
  assign room       = count_r <= CW'(DEPTH - MAX_RES);
  assign head_valid = count_r != '0;
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_r + AW'(pop);
      wr_ptr_r <= wr_ptr_r + AW'(push_n);
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (push && res_cnt_t'(k) < grp.cnt) mem_r[wr_ptr_r + AW'(k)] <= grp.res[k];
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("result queue overfilled");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push && grp.cnt != '0) |-> room)
    else $error("group pushed without room");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (count_r == $past(count_r) - CW'(1)))
    else $error("count did not drop on pop");
`endif

endmodule
